@@ rtl/bdda_pkg.sv @@
// Package for the business-day date adder: field widths, status codes,
// controller/datapath command and status structs, and calendar tables.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package bdda_pkg;

  // Field widths of the request and result ports.
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 12;
  localparam int WDAY_W = 3;
  localparam int STAT_W = 2;

  // Internal widths: year modulo 400, weekday sum, shared multiplier.
  localparam int C400_W  = 9;
  localparam int SUM_W   = 15;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = 31;
  localparam int Q100_W  = 8;
  localparam int Q7_W    = 13;

  // Reciprocal constants: x / 100 = (x * 5243) >> 19 and x / 7 = (x * 37450) >> 18,
  // both exact for x below 43690, which covers every value that reaches them.
  localparam logic [MUL_B_W-1:0] RECIP_100 = 16'd5243;
  localparam logic [MUL_B_W-1:0] RECIP_7   = 16'd37450;
  localparam int SHIFT_100 = 19;
  localparam int SHIFT_7   = 18;

  localparam logic [YEAR_W-1:0] MAX_YEAR  = 14'd9999;
  localparam logic [MON_W-1:0]  MON_FEB   = 4'd2;
  localparam logic [MON_W-1:0]  MON_JAN   = 4'd1;
  localparam logic [MON_W-1:0]  MON_DEC   = 4'd12;
  localparam logic [WDAY_W-1:0] WD_SUN    = 3'd0;
  localparam logic [WDAY_W-1:0] WD_FRI    = 3'd5;
  localparam logic [WDAY_W-1:0] WD_SAT    = 3'd6;
  localparam logic [C400_W-1:0] C400_LAST = 9'd399;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Operand choice of the shared constant multiplier.
  typedef enum logic [1:0] {
    MUL_YEAR,
    MUL_SHIFTED_YEAR,
    MUL_SUM
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     qy_en;
    logic     sum_en;
    logic     wd_en;
    logic     step;
    logic     fin;
    status_t  fin_code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic invalid;
    logic left_zero;
    logic weekend;
    logic overflow;
  } dp_stat_t;

  // Leap year from the year modulo 400.
  function automatic logic is_leap(input logic [C400_W-1:0] c400);
    return (c400[1:0] == 2'd0) && (c400 != 9'd100) && (c400 != 9'd200) &&
           (c400 != 9'd300);
  endfunction

  // Length of a month; zero for a month code that means nothing.
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd2:                             len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:          len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                     len = 5'd31;
      default:                          len = 5'd0;
    endcase
    return len;
  endfunction

  // Month term of the weekday formula, (31 * shifted month) / 12.
  function automatic logic [DAY_W-1:0] month_offset(input logic [MON_W-1:0] month);
    logic [DAY_W-1:0] off;
    case (month)
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd31;
      4'd3:    off = 5'd2;
      4'd4:    off = 5'd5;
      4'd5:    off = 5'd7;
      4'd6:    off = 5'd10;
      4'd7:    off = 5'd12;
      4'd8:    off = 5'd15;
      4'd9:    off = 5'd18;
      4'd10:   off = 5'd20;
      4'd11:   off = 5'd23;
      4'd12:   off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/bdda_datapath.sv @@
// Datapath of the business-day date adder: start registers, weekday setup
// through one shared constant multiplier, the day stepper and result registers.
// Depends on bdda_pkg.
`timescale 1ns / 1ps

module bdda_datapath (
  input  logic                            clk,
  input  bdda_pkg::dp_cmd_t               cmd,
  output bdda_pkg::dp_stat_t              stat,
  input  logic [bdda_pkg::DAY_W-1:0]      start_day,
  input  logic [bdda_pkg::MON_W-1:0]      start_month,
  input  logic [bdda_pkg::YEAR_W-1:0]     start_year,
  input  logic [bdda_pkg::CNT_W-1:0]      work_days,
  output logic [bdda_pkg::DAY_W-1:0]      return_day,
  output logic [bdda_pkg::MON_W-1:0]      return_month,
  output logic [bdda_pkg::YEAR_W-1:0]     return_year,
  output logic [bdda_pkg::WDAY_W-1:0]     return_weekday,
  output logic [bdda_pkg::STAT_W-1:0]     status
);
  import bdda_pkg::*;

  logic [DAY_W-1:0]  sd, d;
  logic [MON_W-1:0]  sm, m;
  logic [YEAR_W-1:0] sy, y;
  logic [CNT_W-1:0]  left;
  logic [C400_W-1:0] c400;
  logic [WDAY_W-1:0] wd, wd0;
  logic [PROD_W-1:0] prod;
  logic [Q100_W-1:0] qy;
  logic [SUM_W-1:0]  sum;

  logic [YEAR_W-1:0]  yy;
  logic [SUM_W-1:0]   mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [Q100_W-1:0]  q100;
  logic [Q7_W-1:0]    q7;
  logic [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]   rem7;
  logic [YEAR_W-1:0]  c400_full;
  logic               leap;
  logic [DAY_W-1:0]   dim;
  logic               at_end;

  // January and February count as months of the previous year.
  assign yy = sy - YEAR_W'((sm == MON_JAN) || (sm == MON_FEB));

  // Shared multiplier by a reciprocal constant.
  always_comb begin
    case (cmd.mul_sel)
      MUL_YEAR:         begin mul_a = SUM_W'(sy);  mul_b = RECIP_100; end
      MUL_SHIFTED_YEAR: begin mul_a = SUM_W'(yy);  mul_b = RECIP_100; end
      MUL_SUM:          begin mul_a = sum;         mul_b = RECIP_7;   end
      default:          begin mul_a = sum;         mul_b = RECIP_7;   end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign q100 = prod[SHIFT_100 +: Q100_W];
  assign q7   = prod[SHIFT_7 +: Q7_W];

  // Weekday sum d + yy + yy/4 - yy/100 + yy/400 + month term, and its remainder.
  assign sum_next = SUM_W'(sd) + SUM_W'(yy) + SUM_W'(yy >> 2) - SUM_W'(q100) +
                    SUM_W'(q100 >> 2) + SUM_W'(month_offset(sm));
  assign rem7 = sum - SUM_W'(SUM_W'(q7) * SUM_W'(7));

  // Year modulo 400 from the quotient by 100.
  assign c400_full = sy - YEAR_W'(YEAR_W'(qy[Q100_W-1:2]) * YEAR_W'(400));

  // Calendar state of the current date.
  assign leap   = is_leap(c400);
  assign dim    = month_days(m, leap);
  assign at_end = (d == dim);

  assign stat.invalid   = (sm == '0) || (sm > MON_DEC) || (sy == '0) || (sy > MAX_YEAR) ||
                          (sd == '0) || (sd > dim);
  assign stat.left_zero = (left == '0);
  assign stat.weekend   = (wd == WD_FRI) || (wd == WD_SAT);
  assign stat.overflow  = at_end && (m == MON_DEC) && (y >= MAX_YEAR);

  // Start capture, setup arithmetic and day stepping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sd   <= start_day;
      sm   <= start_month;
      sy   <= start_year;
      d    <= start_day;
      m    <= start_month;
      y    <= start_year;
      left <= work_days;
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.qy_en) begin
      qy <= q100;
    end
    if (cmd.sum_en) begin
      sum  <= sum_next;
      c400 <= c400_full[C400_W-1:0];
    end
    if (cmd.wd_en) begin
      wd  <= rem7[WDAY_W-1:0];
      wd0 <= rem7[WDAY_W-1:0];
    end
    if (cmd.step) begin
      if (at_end) begin
        d <= DAY_W'(1);
        if (m == MON_DEC) begin
          m    <= MON_JAN;
          y    <= y + YEAR_W'(1);
          c400 <= (c400 == C400_LAST) ? '0 : c400 + C400_W'(1);
        end else begin
          m <= m + MON_W'(1);
        end
      end else begin
        d <= d + DAY_W'(1);
      end
      wd <= (wd == WD_SAT) ? WD_SUN : wd + WDAY_W'(1);
      if (!stat.left_zero && !stat.weekend) begin
        left <= left - CNT_W'(1);
      end
    end
  end

  // Result registers, written once per request.
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status <= cmd.fin_code;
      case (cmd.fin_code)
        ST_OK: begin
          return_day     <= d;
          return_month   <= m;
          return_year    <= y;
          return_weekday <= wd;
        end
        ST_INVALID: begin
          return_day     <= sd;
          return_month   <= sm;
          return_year    <= sy;
          return_weekday <= WD_SUN;
        end
        default: begin
          return_day     <= sd;
          return_month   <= sm;
          return_year    <= sy;
          return_weekday <= wd0;
        end
      endcase
    end
  end

  // A working day consumed by a step lowers the count by one.
  a_count_down: assert property (@(posedge clk)
    (cmd.step && !stat.left_zero && !stat.weekend) |=> (left == $past(left) - CNT_W'(1)))
    else $error("work day count did not decrement");

  // The weekday advances cyclically with every step.
  a_wday_step: assert property (@(posedge clk)
    cmd.step |=> (wd == (($past(wd) == WD_SAT) ? WD_SUN : $past(wd) + WDAY_W'(1))))
    else $error("weekday did not advance with the date");

  // Year rollover lands on the first of January.
  a_new_year: assert property (@(posedge clk)
    (cmd.step && at_end && (m == MON_DEC)) |=> ((m == MON_JAN) && (d == DAY_W'(1))))
    else $error("year rollover did not reach January 1");

endmodule

@@ rtl/bdda_ctrl.sv @@
// Controller of the business-day date adder: sequences weekday setup, the
// validity check, day stepping and the result strobe.
// Depends on bdda_pkg.
`timescale 1ns / 1ps

module bdda_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output bdda_pkg::dp_cmd_t  cmd,
  input  bdda_pkg::dp_stat_t stat
);
  import bdda_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_YEAR,
    S_MUL_SHIFTED,
    S_SUM,
    S_MOD7,
    S_WDAY,
    S_RUN
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_SUM;
    cmd.fin_code = ST_OK;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_YEAR;
        end
      end
      S_MUL_YEAR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_YEAR;
        state_next  = S_MUL_SHIFTED;
      end
      S_MUL_SHIFTED: begin
        cmd.qy_en   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SHIFTED_YEAR;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_MOD7;
      end
      S_MOD7: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SUM;
        state_next  = S_WDAY;
      end
      S_WDAY: begin
        if (stat.invalid) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = ST_INVALID;
          state_next   = S_IDLE;
        end else begin
          cmd.wd_en  = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!stat.left_zero || stat.weekend) begin
          if (stat.overflow) begin
            cmd.fin      = 1'b1;
            cmd.fin_code = ST_OVERFLOW;
            state_next   = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          cmd.fin      = 1'b1;
          cmd.fin_code = ST_OK;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.fin;
    end
  end

  // The strobe follows the end of a request, when the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // The date never steps past the last supported year.
  a_no_overflow_step: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !stat.overflow)
    else $error("step issued at year overflow");

  // Work starts only on an accepted request.
  a_start_req: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a request");

endmodule

@@ rtl/business_day_date_adder_unit.sv @@
// Top level of the business-day date adder: controller and datapath.
// Depends on bdda_pkg, bdda_ctrl and bdda_datapath.
`timescale 1ns / 1ps

// Usage:
//   A request (start date and number of working days) is taken at a rising
//   clock edge where start is high and busy is low. Friday and Saturday are
//   weekend days. The result (return date, its weekday, status) appears on the
//   result ports for exactly one cycle with done high; the receiver cannot
//   stall it, and the ports keep their value until the next result.
//   Setup computes the weekday via one shared constant multiplier, then does
//   the validity check. The day stepper then advances one calendar day per
//   clock until the working days (up to 4095) are used up and the date is not
//   a weekend day; the result registers are then written, and the strobe is
//   registered from that same command. An invalid start date finishes at the
//   validity check, the last setup step; a year overflow finishes when the
//   stepper reaches December 31, 9999.
//   One request is in flight at a time; busy drops in the cycle of the strobe,
//   so the next request can be taken then.
//   Reset (rst, synchronous, active high) returns the controller to idle and
//   clears the strobe; result ports are undefined until the first result.

module business_day_date_adder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bdda_pkg::DAY_W-1:0]  start_day,
  input  logic [bdda_pkg::MON_W-1:0]  start_month,
  input  logic [bdda_pkg::YEAR_W-1:0] start_year,
  input  logic [bdda_pkg::CNT_W-1:0]  work_days,
  output logic                        done,
  output logic [bdda_pkg::DAY_W-1:0]  return_day,
  output logic [bdda_pkg::MON_W-1:0]  return_month,
  output logic [bdda_pkg::YEAR_W-1:0] return_year,
  output logic [bdda_pkg::WDAY_W-1:0] return_weekday,
  output logic [bdda_pkg::STAT_W-1:0] status
);
  import bdda_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing of one request.
  bdda_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Calendar arithmetic and result registers.
  bdda_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .stat           (stat),
    .start_day      (start_day),
    .start_month    (start_month),
    .start_year     (start_year),
    .work_days      (work_days),
    .return_day     (return_day),
    .return_month   (return_month),
    .return_year    (return_year),
    .return_weekday (return_weekday),
    .status         (status)
  );

endmodule

@@ dv/business_day_date_adder_unit_tb.sv @@
// Self-checking testbench for business_day_date_adder_unit: directed and random requests,
// each checked against a business-day calendar predictor kept inside this file.
// Depends on bdda_pkg and the RTL of business_day_date_adder_unit.
`timescale 1ns / 1ps

module business_day_date_adder_unit_tb;
  import bdda_pkg::*;

  localparam int RANDOM_REQUESTS = 77;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 12;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [CNT_W-1:0]  count;
  } date_request_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [WDAY_W-1:0] weekday;
    status_t           code;
  } return_date_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [DAY_W-1:0]  start_day = '0;
  logic [MON_W-1:0]  start_month = '0;
  logic [YEAR_W-1:0] start_year = '0;
  logic [CNT_W-1:0]  work_days = '0;
  logic done;
  logic [DAY_W-1:0]  return_day;
  logic [MON_W-1:0]  return_month;
  logic [YEAR_W-1:0] return_year;
  logic [WDAY_W-1:0] return_weekday;
  logic [STAT_W-1:0] status;

  date_request_t pending_requests[$];
  return_date_t  expected_returns[$];
  int mismatch_count = 0;
  int gap_left = 0;
  int calm_left = 0;
  int idle_cycles = 0;

  business_day_date_adder_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .start_day      (start_day),
    .start_month    (start_month),
    .start_year     (start_year),
    .work_days      (work_days),
    .done           (done),
    .return_day     (return_day),
    .return_month   (return_month),
    .return_year    (return_year),
    .return_weekday (return_weekday),
    .status         (status)
  );

  always #10 clk = ~clk;

  // Days in a month of the Gregorian calendar; zero for a month that does not exist.
  function automatic int unsigned month_length(input int unsigned year, input int unsigned month);
    bit leap;
    leap = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
    case (month)
      2:              return leap ? 29 : 28;
      4, 6, 9, 11:    return 30;
      1, 3, 5, 7, 8,
      10, 12:         return 31;
      default:        return 0;
    endcase
  endfunction

  function automatic bit is_rest_day(input int unsigned wd);
    return (wd == WD_FRI) || (wd == WD_SAT);
  endfunction

  // Moves the date one day on; returns 0 when that would leave year 9999.
  function automatic bit next_calendar_day(inout int unsigned d, inout int unsigned m,
                                           inout int unsigned y, inout int unsigned wd);
    if (d == month_length(y, m)) begin
      if (m == 12) begin
        if (y >= MAX_YEAR) return 1'b0;
        m = 1;
        y = y + 1;
      end else begin
        m = m + 1;
      end
      d = 1;
    end else begin
      d = d + 1;
    end
    wd = (wd + 1) % 7;
    return 1'b1;
  endfunction

  // Return date after the given number of working days, weekend skip included.
  function automatic return_date_t add_business_days(input date_request_t req);
    return_date_t r;
    int unsigned d, m, y, wd, wd0, left, a, yy, mm;
    bit ok;
    r.day = req.day;
    r.month = req.month;
    r.year = req.year;
    r.weekday = WD_SUN;
    r.code = ST_INVALID;
    if (req.month < 1 || req.month > 12 || req.year < 1 || req.year > MAX_YEAR ||
        req.day < 1 || req.day > month_length(req.year, req.month))
      return r;
    // Weekday of the start date, counting January and February in the prior year.
    a = (14 - req.month) / 12;
    yy = req.year - a;
    mm = req.month + 12 * a - 2;
    wd0 = (req.day + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    d = req.day;
    m = req.month;
    y = req.year;
    wd = wd0;
    left = req.count;
    ok = 1'b1;
    while (ok && left != 0) begin
      if (!is_rest_day(wd)) left = left - 1;
      ok = next_calendar_day(d, m, y, wd);
    end
    while (ok && is_rest_day(wd)) ok = next_calendar_day(d, m, y, wd);
    if (!ok) begin
      r.weekday = WDAY_W'(wd0);
      r.code = ST_OVERFLOW;
      return r;
    end
    r.day = DAY_W'(d);
    r.month = MON_W'(m);
    r.year = YEAR_W'(y);
    r.weekday = WDAY_W'(wd);
    r.code = ST_OK;
    return r;
  endfunction

  task automatic queue_request(input int unsigned d, input int unsigned m,
                               input int unsigned y, input int unsigned c);
    date_request_t req;
    req.day = DAY_W'(d);
    req.month = MON_W'(m);
    req.year = YEAR_W'(y);
    req.count = CNT_W'(c);
    pending_requests.push_back(req);
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("at %0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
  endtask

  // Request driver: holds start until accepted, then waits a random gap once busy drops.
  always @(posedge clk) begin : request_driver
    date_request_t next_req;
    logic next_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = 1'b0;
      if (start && !busy) begin
        next_req.day = start_day;
        next_req.month = start_month;
        next_req.year = start_year;
        next_req.count = work_days;
        expected_returns.push_back(add_business_days(next_req));
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          calm_left = $urandom_range(4, 12);
          gap_left = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(8, 40);
        end else begin
          gap_left = $urandom_range(0, 3);
        end
      end
      if (start && busy) begin
        next_start = 1'b1;
      end else if (gap_left > 0) begin
        if (!busy) gap_left--;
      end else if (pending_requests.size() > 0) begin
        next_req = pending_requests.pop_front();
        start_day <= next_req.day;
        start_month <= next_req.month;
        start_year <= next_req.year;
        work_days <= next_req.count;
        next_start = 1'b1;
      end
      start <= next_start;
    end
  end

  // Result monitor: every strobe is matched against the oldest expected return date.
  always @(posedge clk) begin : result_monitor
    return_date_t want;
    if (!rst && done) begin
      if (expected_returns.size() == 0) begin
        report_mismatch("unexpected result", return_day, 0);
      end else begin
        want = expected_returns.pop_front();
        if (return_day !== want.day) report_mismatch("return_day", return_day, want.day);
        if (return_month !== want.month)
          report_mismatch("return_month", return_month, want.month);
        if (return_year !== want.year) report_mismatch("return_year", return_year, want.year);
        if (return_weekday !== want.weekday)
          report_mismatch("return_weekday", return_weekday, want.weekday);
        if (status !== want.code) report_mismatch("status", status, want.code);
      end
    end
  end

  // Watchdog: too long without any request or result accepted ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("business_day_date_adder_unit_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned kind, pick, d, m, y, c;

    // Extremes of the fields and the calendar corner cases.
    queue_request(1, 1, 1, 0);
    queue_request(1, 1, 1, 4095);
    queue_request(31, 12, 9999, 0);      // Friday on the last day: skip overflows
    queue_request(31, 12, 9999, 1);
    queue_request(30, 12, 9999, 0);
    queue_request(1, 1, 9990, 4095);     // stepping runs out of years
    queue_request(29, 2, 2000, 5);       // leap year by the 400 rule
    queue_request(29, 2, 1900, 1);       // century year that is not leap
    queue_request(29, 2, 2024, 3);
    queue_request(29, 2, 2023, 2);
    queue_request(0, 5, 2020, 1);        // day zero
    queue_request(31, 4, 2021, 1);       // day past the end of the month
    queue_request(31, 15, 16383, 4095);  // every bit set
    queue_request(1, 0, 2000, 1);
    queue_request(1, 13, 2000, 1);
    queue_request(1, 1, 0, 1);
    queue_request(1, 1, 10000, 1);
    queue_request(1, 3, 2024, 0);        // Friday start with nothing to consume
    queue_request(2, 3, 2024, 0);        // Saturday start with nothing to consume
    queue_request(1, 3, 2024, 1);        // Friday start does not use up a day
    queue_request(31, 12, 2023, 10);     // year rollover
    queue_request(28, 2, 2023, 2);       // month rollover, short February
    queue_request(31, 1, 2024, 1);

    // Random part: mostly valid dates with small counts, some noise and long counts.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        d = $urandom;
        m = $urandom;
        y = $urandom;
      end else begin
        if (kind < 5) begin
          y = MAX_YEAR;
          m = $urandom_range(11, 12);
        end else if (kind == 5) begin
          y = 4 * $urandom_range(1, 2499);
          m = 2;
        end else begin
          y = $urandom_range(1, MAX_YEAR);
          m = $urandom_range(1, 12);
        end
        d = (kind == 5) ? $urandom_range(27, month_length(y, m))
                        : $urandom_range(1, month_length(y, m));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) c = $urandom_range(0, 4095);
      else if (pick == 1) c = 0;
      else c = $urandom_range(1, 40);
      queue_request(d, m, y, c);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait until every request is taken and every result has arrived.
    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_returns.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("business_day_date_adder_unit_tb passed");
    end else begin
      $display("business_day_date_adder_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bdda_pkg.sv
rtl/bdda_datapath.sv
rtl/bdda_ctrl.sv
rtl/business_day_date_adder_unit.sv
dv/business_day_date_adder_unit_tb.sv
